>>> src/setsq_pkg.sv
// Package for the sound effect tone sequencer: widths, command codes, FSM states,
// and the fixed note ROM and effect table contents.
// No dependencies; used by the top level, the checker and the testbench.
package setsq_pkg;

  // Storage sizes
  localparam int NOTE_ROM_DEPTH = 64;
  localparam int EFFECT_COUNT   = 16;
  localparam int ADDR_W         = $clog2(NOTE_ROM_DEPTH);
  localparam int PTR_W          = ADDR_W + 1;
  localparam int EFF_W          = $clog2(EFFECT_COUNT);

  // Field widths
  localparam int FREQ_W  = 11;
  localparam int MS_W    = 8;
  localparam int CLK_W   = 27;
  localparam int WRAP_W  = 16;
  localparam int DUTY_W  = 8;
  localparam int CMD_W   = 2;
  localparam int CFG_W   = 27;
  localparam int CFGI_W  = 2;
  localparam int CNT_W   = $clog2(CLK_W + 1);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START_IDLE = 2'd2;

  // Configuration register indexes
  localparam logic [CFGI_W-1:0] REG_TONE_CLK = 2'd0;
  localparam logic [CFGI_W-1:0] REG_WRAP_MIN = 2'd1;
  localparam logic [CFGI_W-1:0] REG_WRAP_MAX = 2'd2;
  localparam logic [CFGI_W-1:0] REG_DUTY_DIV = 2'd3;

  // Reset values
  localparam logic [CLK_W-1:0]  TONE_CLK_RST = 27'd31250000;
  localparam logic [WRAP_W-1:0] WRAP_MIN_RST = 16'd100;
  localparam logic [WRAP_W-1:0] WRAP_MAX_RST = 16'd65534;
  localparam logic [DUTY_W-1:0] DUTY_DIV_RST = 8'd48;
  localparam logic [WRAP_W-1:0] WRAP_RST     = 16'hFFFF;

  // Divider step counts for the period and level divisions
  localparam logic [CNT_W-1:0] PER_STEPS = CNT_W'(CLK_W);
  localparam logic [CNT_W-1:0] LVL_STEPS = CNT_W'(WRAP_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROM,
    ST_DIVP,
    ST_CLAMP,
    ST_DIVL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [MS_W-1:0]   ms;
  } note_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
  } effect_t;

  // Note ROM contents: frequency in Hz, duration in ms
  function automatic note_t note_rom(input logic [ADDR_W-1:0] addr);
    note_t n;
    n = '0;
    case (addr)
      ADDR_W'(0):  n = '{11'd440,  8'd35};
      ADDR_W'(1):  n = '{11'd523,  8'd45};
      ADDR_W'(2):  n = '{11'd0,    8'd30};
      ADDR_W'(3):  n = '{11'd523,  8'd35};
      ADDR_W'(4):  n = '{11'd659,  8'd50};
      ADDR_W'(5):  n = '{11'd0,    8'd30};
      ADDR_W'(6):  n = '{11'd784,  8'd70};
      ADDR_W'(7):  n = '{11'd698,  8'd70};
      ADDR_W'(8):  n = '{11'd659,  8'd80};
      ADDR_W'(9):  n = '{11'd587,  8'd90};
      ADDR_W'(10): n = '{11'd523,  8'd100};
      ADDR_W'(11): n = '{11'd466,  8'd120};
      ADDR_W'(12): n = '{11'd392,  8'd150};
      ADDR_W'(13): n = '{11'd330,  8'd190};
      ADDR_W'(14): n = '{11'd0,    8'd80};
      ADDR_W'(15): n = '{11'd400,  8'd45};
      ADDR_W'(16): n = '{11'd0,    8'd20};
      ADDR_W'(17): n = '{11'd800,  8'd45};
      ADDR_W'(18): n = '{11'd0,    8'd20};
      ADDR_W'(19): n = '{11'd740,  8'd35};
      ADDR_W'(20): n = '{11'd988,  8'd45};
      ADDR_W'(21): n = '{11'd0,    8'd20};
      ADDR_W'(22): n = '{11'd220,  8'd80};
      ADDR_W'(23): n = '{11'd180,  8'd120};
      ADDR_W'(24): n = '{11'd0,    8'd40};
      ADDR_W'(25): n = '{11'd330,  8'd18};
      ADDR_W'(26): n = '{11'd0,    8'd12};
      ADDR_W'(27): n = '{11'd900,  8'd28};
      ADDR_W'(28): n = '{11'd1100, 8'd24};
      ADDR_W'(29): n = '{11'd0,    8'd16};
      ADDR_W'(30): n = '{11'd784,  8'd35};
      ADDR_W'(31): n = '{11'd1046, 8'd55};
      ADDR_W'(32): n = '{11'd0,    8'd20};
      ADDR_W'(33): n = '{11'd330,  8'd55};
      ADDR_W'(34): n = '{11'd262,  8'd70};
      ADDR_W'(35): n = '{11'd196,  8'd110};
      ADDR_W'(36): n = '{11'd0,    8'd35};
      default:     n = '0;
    endcase
    return n;
  endfunction

  // Effect table: first note and note count; unused slots are empty
  function automatic effect_t effect_rom(input logic [EFF_W-1:0] id);
    effect_t e;
    e = '0;
    case (id)
      EFF_W'(0):  e = '{ADDR_W'(0),  ADDR_W'(3)};
      EFF_W'(1):  e = '{ADDR_W'(3),  ADDR_W'(3)};
      EFF_W'(2):  e = '{ADDR_W'(6),  ADDR_W'(9)};
      EFF_W'(3):  e = '{ADDR_W'(15), ADDR_W'(2)};
      EFF_W'(4):  e = '{ADDR_W'(17), ADDR_W'(2)};
      EFF_W'(5):  e = '{ADDR_W'(19), ADDR_W'(3)};
      EFF_W'(6):  e = '{ADDR_W'(22), ADDR_W'(3)};
      EFF_W'(7):  e = '{ADDR_W'(25), ADDR_W'(2)};
      EFF_W'(8):  e = '{ADDR_W'(27), ADDR_W'(3)};
      EFF_W'(9):  e = '{ADDR_W'(30), ADDR_W'(3)};
      EFF_W'(10): e = '{ADDR_W'(33), ADDR_W'(4)};
      default:    e = '0;
    endcase
    return e;
  endfunction

endpackage

>>> src/sound_effect_tone_sequencer_top.sv
// Top level of the sound effect tone sequencer: command decode, note ROM with
// registered read, shared serial divider, clamp stage and output register.
// Depends on setsq_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one item carries in_cmd and in_effect_id.
//   Command 0 is the 1 ms tick, 1 starts an effect, 2 starts it only when idle,
//   3 does nothing. Every accepted item gives exactly one result item on the
//   out_ channel showing wrap, level, tone_on and busy after that command.
//   Path to a result: a start, an ignored command, a tick that only counts
//   down and a tick that ends the sequence go straight to the posting state
//   (ST_DONE). A tick that loads a note with a nonzero frequency passes a
//   ROM read, 27 steps of the serial divider for the period, a clamp step,
//   16 divider steps for the level and ST_DONE, which posts the result. A
//   silent note goes from the ROM read straight to ST_DONE. One item is in
//   work at a time; in_stall drops as the result posts. The output register
//   holds a finished result while out_stall is high; the next item is
//   accepted meanwhile and its result waits until the register frees up.
//   Config writes (cfg_we/cfg_index/cfg_wdata) must be made only while idle;
//   the block does not enforce it. Reset (rst_n low, synchronous) restores
//   config defaults, stops any sequence, sets wrap to all ones and level to
//   zero, and drops out_valid.
module sound_effect_tone_sequencer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration port
  input  logic                         cfg_we,
  input  logic [setsq_pkg::CFGI_W-1:0] cfg_index,
  input  logic [setsq_pkg::CFG_W-1:0]  cfg_wdata,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [setsq_pkg::CMD_W-1:0]  in_cmd,
  input  logic [setsq_pkg::EFF_W-1:0]  in_effect_id,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [setsq_pkg::WRAP_W-1:0] out_pwm_wrap,
  output logic [setsq_pkg::WRAP_W-1:0] out_pwm_level,
  output logic                         out_tone_on,
  output logic                         out_busy_res
);

  localparam int CLK_W  = setsq_pkg::CLK_W;
  localparam int WRAP_W = setsq_pkg::WRAP_W;
  localparam int PTR_W  = setsq_pkg::PTR_W;
  localparam int ADDR_W = setsq_pkg::ADDR_W;
  localparam int MS_W   = setsq_pkg::MS_W;
  localparam int CNT_W  = setsq_pkg::CNT_W;

  // Configuration registers
  logic [CLK_W-1:0]              tone_clk_r;
  logic [WRAP_W-1:0]             wrap_min_r;
  logic [WRAP_W-1:0]             wrap_max_r;
  logic [setsq_pkg::DUTY_W-1:0]  duty_div_r;

  // Sequencer state
  setsq_pkg::state_t state_r, state_nxt;
  logic              active_r, active_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [PTR_W-1:0]  end_r, end_nxt;
  logic [MS_W-1:0]   ms_r, ms_nxt;
  logic [WRAP_W-1:0] wrap_r, wrap_nxt;
  logic [WRAP_W-1:0] level_r, level_nxt;

  // Divider registers
  logic [WRAP_W-1:0] div_rem_r, div_rem_nxt;
  logic [CLK_W-1:0]  div_quo_r, div_quo_nxt;
  logic [WRAP_W-1:0] div_dvs_r, div_dvs_nxt;
  logic [CNT_W-1:0]  div_cnt_r, div_cnt_nxt;

  // Note ROM read data
  setsq_pkg::note_t  rom_q_r;

  // Output register
  logic              out_valid_r;
  logic [WRAP_W-1:0] out_wrap_r;
  logic [WRAP_W-1:0] out_level_r;
  logic              out_busy_r;

  logic              in_acc;
  logic              out_free;
  logic              tick_go;
  logic              tick_load;
  logic              tick_stop;
  logic              do_start;
  logic [MS_W-1:0]   ms_dec;
  setsq_pkg::effect_t eff;

  // Divider step and clamp signals
  logic [WRAP_W:0]   rem_sh;
  logic              rem_ge;
  logic [WRAP_W:0]   rem_sub;
  logic [CLK_W-1:0]  quo_step;
  logic [WRAP_W-1:0] rem_step;
  logic              div_last;
  logic [CLK_W-1:0]  q_m1;
  logic              over_max;
  logic [WRAP_W-1:0] top_hi;
  logic [WRAP_W-1:0] top_clamp;

  assign in_stall  = (state_r != setsq_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_pwm_wrap  = out_wrap_r;
  assign out_pwm_level = out_level_r;
  assign out_tone_on   = (out_level_r != '0);
  assign out_busy_res  = out_busy_r;

  // Command decode
  assign ms_dec    = ms_r - MS_W'(1);
  assign tick_go   = in_acc && (in_cmd == setsq_pkg::CMD_TICK) && active_r &&
                     ((ms_r == '0) || (ms_dec == '0));
  assign tick_stop = tick_go && ((ptr_r >= end_r) ||
                                 (ptr_r >= PTR_W'(setsq_pkg::NOTE_ROM_DEPTH)));
  assign tick_load = tick_go && !tick_stop;
  assign do_start  = in_acc && ((in_cmd == setsq_pkg::CMD_START) ||
                     ((in_cmd == setsq_pkg::CMD_START_IDLE) && !active_r));
  assign eff       = setsq_pkg::effect_rom(in_effect_id);

  // Restoring divider step, one quotient bit per cycle
  assign rem_sh   = {div_rem_r, div_quo_r[CLK_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, div_dvs_r});
  assign rem_sub  = rem_sh - {1'b0, div_dvs_r};
  assign rem_step = rem_ge ? rem_sub[WRAP_W-1:0] : rem_sh[WRAP_W-1:0];
  assign quo_step = {div_quo_r[CLK_W-2:0], rem_ge};
  assign div_last = (div_cnt_r == CNT_W'(1));

  // Period clamp: quotient minus one, max clamp then min clamp
  assign q_m1      = div_quo_r - CLK_W'(1);
  assign over_max  = (div_quo_r == '0) || (q_m1 > CLK_W'(wrap_max_r));
  assign top_hi    = over_max ? wrap_max_r : q_m1[WRAP_W-1:0];
  assign top_clamp = (top_hi < wrap_min_r) ? wrap_min_r : top_hi;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      setsq_pkg::ST_IDLE: begin
        if (tick_load) begin
          state_nxt = setsq_pkg::ST_ROM;
        end else if (in_acc) begin
          state_nxt = setsq_pkg::ST_DONE;
        end
      end
      setsq_pkg::ST_ROM: begin
        state_nxt = (rom_q_r.freq == '0) ? setsq_pkg::ST_DONE : setsq_pkg::ST_DIVP;
      end
      setsq_pkg::ST_DIVP: begin
        if (div_last) state_nxt = setsq_pkg::ST_CLAMP;
      end
      setsq_pkg::ST_CLAMP: begin
        state_nxt = setsq_pkg::ST_DIVL;
      end
      setsq_pkg::ST_DIVL: begin
        if (div_last) state_nxt = setsq_pkg::ST_DONE;
      end
      setsq_pkg::ST_DONE: begin
        if (out_free) state_nxt = setsq_pkg::ST_IDLE;
      end
      default: state_nxt = setsq_pkg::ST_IDLE;
    endcase
  end

  // Datapath next values
  always_comb begin
    active_nxt  = active_r;
    ptr_nxt     = ptr_r;
    end_nxt     = end_r;
    ms_nxt      = ms_r;
    wrap_nxt    = wrap_r;
    level_nxt   = level_r;
    div_rem_nxt = div_rem_r;
    div_quo_nxt = div_quo_r;
    div_dvs_nxt = div_dvs_r;
    div_cnt_nxt = div_cnt_r;
    case (state_r)
      setsq_pkg::ST_IDLE: begin
        if (do_start) begin
          active_nxt = 1'b1;
          ptr_nxt    = PTR_W'(eff.start);
          end_nxt    = PTR_W'(eff.start) + PTR_W'(eff.len);
          ms_nxt     = '0;
        end else if (in_acc && (in_cmd == setsq_pkg::CMD_TICK) && active_r) begin
          if (ms_r != '0) ms_nxt = ms_dec;
          if (tick_stop) begin
            active_nxt = 1'b0;
            ptr_nxt    = '0;
            end_nxt    = '0;
            level_nxt  = '0;
          end
        end
      end
      setsq_pkg::ST_ROM: begin
        // note read is back: set duration, advance, start period division
        ms_nxt      = rom_q_r.ms;
        ptr_nxt     = ptr_r + PTR_W'(1);
        div_rem_nxt = '0;
        div_quo_nxt = tone_clk_r;
        div_dvs_nxt = WRAP_W'(rom_q_r.freq);
        div_cnt_nxt = setsq_pkg::PER_STEPS;
        if (rom_q_r.freq == '0) level_nxt = '0;
      end
      setsq_pkg::ST_DIVP, setsq_pkg::ST_DIVL: begin
        div_rem_nxt = rem_step;
        div_quo_nxt = quo_step;
        div_cnt_nxt = div_cnt_r - CNT_W'(1);
        if ((state_r == setsq_pkg::ST_DIVL) && div_last) begin
          level_nxt = quo_step[WRAP_W-1:0];
        end
      end
      setsq_pkg::ST_CLAMP: begin
        // wrap known: divide it by the duty divisor, zero taken as one
        wrap_nxt    = top_clamp;
        div_rem_nxt = '0;
        div_quo_nxt = {top_clamp, (CLK_W - WRAP_W)'(0)};
        div_dvs_nxt = (duty_div_r == '0) ? WRAP_W'(1) : WRAP_W'(duty_div_r);
        div_cnt_nxt = setsq_pkg::LVL_STEPS;
      end
      default: begin
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= setsq_pkg::ST_IDLE;
      active_r <= 1'b0;
      ptr_r    <= '0;
      end_r    <= '0;
      ms_r     <= '0;
      wrap_r   <= setsq_pkg::WRAP_RST;
      level_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      ptr_r    <= ptr_nxt;
      end_r    <= end_nxt;
      ms_r     <= ms_nxt;
      wrap_r   <= wrap_nxt;
      level_r  <= level_nxt;
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    div_rem_r <= div_rem_nxt;
    div_quo_r <= div_quo_nxt;
    div_dvs_r <= div_dvs_nxt;
    div_cnt_r <= div_cnt_nxt;
  end

  // Note ROM, registered read at the current pointer
  always_ff @(posedge clk) begin
    rom_q_r <= setsq_pkg::note_rom(ptr_r[ADDR_W-1:0]);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_clk_r <= setsq_pkg::TONE_CLK_RST;
      wrap_min_r <= setsq_pkg::WRAP_MIN_RST;
      wrap_max_r <= setsq_pkg::WRAP_MAX_RST;
      duty_div_r <= setsq_pkg::DUTY_DIV_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        setsq_pkg::REG_TONE_CLK: tone_clk_r <= cfg_wdata[CLK_W-1:0];
        setsq_pkg::REG_WRAP_MIN: wrap_min_r <= cfg_wdata[WRAP_W-1:0];
        setsq_pkg::REG_WRAP_MAX: wrap_max_r <= cfg_wdata[WRAP_W-1:0];
        setsq_pkg::REG_DUTY_DIV: duty_div_r <= cfg_wdata[setsq_pkg::DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == setsq_pkg::ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == setsq_pkg::ST_DONE) && out_free) begin
      out_wrap_r  <= wrap_r;
      out_level_r <= level_r;
      out_busy_r  <= active_r;
    end
  end

endmodule

>>> src/setsq_checker.sv
// Port-level checker for the sound effect tone sequencer, with its bind.
// Depends on setsq_pkg and sound_effect_tone_sequencer_top.
module setsq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [setsq_pkg::WRAP_W-1:0] out_pwm_wrap,
  input logic [setsq_pkg::WRAP_W-1:0] out_pwm_level,
  input logic                         out_tone_on,
  input logic                         out_busy_res
);

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pwm_wrap) && $stable(out_pwm_level))
    else $error("stalled result changed");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // tone_on tracks a nonzero level
  a_tone_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tone_on == (out_pwm_level != '0)))
    else $error("tone_on does not match level");

  // A tone only sounds while a sequence is active
  a_tone_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tone_on |-> out_busy_res)
    else $error("tone on while idle");

endmodule

bind sound_effect_tone_sequencer_top setsq_checker u_setsq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_pwm_wrap  (out_pwm_wrap),
  .out_pwm_level (out_pwm_level),
  .out_tone_on   (out_tone_on),
  .out_busy_res  (out_busy_res)
);

>>> tb/tb_sound_effect_tone_sequencer_top.sv
// Self-checking testbench for sound_effect_tone_sequencer_top: drives ticks and start
// commands, predicts wrap, level, tone and busy for every item and checks each result.
// Depends on setsq_pkg and the sequencer RTL.
module tb_sound_effect_tone_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import setsq_pkg::*;

  // Command 3 has no package name; the block ignores it
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SONG_NOTES   = 37;
  localparam int SONG_FX      = 11;
  localparam int JUNK_WRAP_W  = CFG_W - WRAP_W;
  localparam int JUNK_DUTY_W  = CFG_W - DUTY_W;

  typedef struct packed {
    logic [WRAP_W-1:0] wrap;
    logic [WRAP_W-1:0] level;
    logic              tone_on;
    logic              busy;
  } tone_out_t;

  // Note and effect contents of the sequencer, kept here for prediction
  int unsigned tune_hz [SONG_NOTES] = '{
    440, 523, 0, 523, 659, 0, 784, 698, 659, 587, 523, 466, 392, 330, 0,
    400, 0, 800, 0, 740, 988, 0, 220, 180, 0, 330, 0, 900, 1100, 0,
    784, 1046, 0, 330, 262, 196, 0};
  int unsigned tune_ms [SONG_NOTES] = '{
    35, 45, 30, 35, 50, 30, 70, 70, 80, 90, 100, 120, 150, 190, 80,
    45, 20, 45, 20, 35, 45, 20, 80, 120, 40, 18, 12, 28, 24, 16,
    35, 55, 20, 55, 70, 110, 35};
  int unsigned fx_first [SONG_FX] = '{0, 3, 6, 15, 17, 19, 22, 25, 27, 30, 33};
  int unsigned fx_count [SONG_FX] = '{3, 3, 9, 2, 2, 3, 3, 2, 3, 3, 4};
  // Effects short enough to play to the end within one random run
  logic [EFF_W-1:0] brief_fx [5] = '{4'd3, 4'd4, 4'd7, 4'd8, 4'd12};

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                cfg_we       = 1'b0;
  logic [CFGI_W-1:0]   cfg_index    = REG_TONE_CLK;
  logic [CFG_W-1:0]    cfg_wdata    = '0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_cmd       = CMD_TICK;
  logic [EFF_W-1:0]    in_effect_id = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [WRAP_W-1:0]   out_pwm_wrap;
  logic [WRAP_W-1:0]   out_pwm_level;
  logic                out_tone_on;
  logic                out_busy_res;

  // Predictor copy of configuration and sequencer state
  logic [CLK_W-1:0]  m_tone_clk = TONE_CLK_RST;
  logic [WRAP_W-1:0] m_wrap_lo  = WRAP_MIN_RST;
  logic [WRAP_W-1:0] m_wrap_hi  = WRAP_MAX_RST;
  logic [DUTY_W-1:0] m_duty     = DUTY_DIV_RST;
  logic              m_playing  = 1'b0;
  logic [PTR_W-1:0]  m_note     = '0;
  logic [PTR_W-1:0]  m_last     = '0;
  logic [MS_W-1:0]   m_ms_left  = '0;
  logic [WRAP_W-1:0] m_wrap     = WRAP_RST;
  logic [WRAP_W-1:0] m_level    = '0;

  tone_out_t tone_expect_q [$];
  int        faults     = 0;
  int        cycles     = 0;
  int        stall_left = 0;
  bit        calm       = 1'b0;

  sound_effect_tone_sequencer_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_effect_id (in_effect_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pwm_wrap (out_pwm_wrap),
    .out_pwm_level(out_pwm_level),
    .out_tone_on  (out_tone_on),
    .out_busy_res (out_busy_res)
  );

  always #5ns clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: run limit reached, %0d results outstanding", $time, tone_expect_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Advance the predicted sequencer by one item and return what it shows after it
  function automatic tone_out_t predict_tone(input logic [CMD_W-1:0] cmd,
                                             input logic [EFF_W-1:0] id);
    logic [31:0]       top;
    logic [WRAP_W-1:0] div;
    tone_out_t         r;
    if (cmd == CMD_START || (cmd == CMD_START_IDLE && !m_playing)) begin
      // unused slots start an empty sequence
      m_playing = 1'b1;
      m_note    = (id < SONG_FX) ? PTR_W'(fx_first[id]) : '0;
      m_last    = m_note + ((id < SONG_FX) ? PTR_W'(fx_count[id]) : '0);
      m_ms_left = '0;
    end else if (cmd == CMD_TICK && m_playing) begin
      if (m_ms_left != '0) m_ms_left = m_ms_left - 1'b1;
      if (m_ms_left == '0) begin
        if (m_note >= m_last || m_note >= NOTE_ROM_DEPTH) begin
          m_playing = 1'b0;
          m_note    = '0;
          m_last    = '0;
          m_level   = '0;
        end else begin
          if (tune_hz[m_note] == 0) begin
            m_level = '0;
          end else begin
            // quotient zero wraps to all ones; the minimum clamp wins over the maximum
            top = 32'(m_tone_clk) / tune_hz[m_note] - 32'd1;
            if (top > 32'(m_wrap_hi)) top = 32'(m_wrap_hi);
            if (top < 32'(m_wrap_lo)) top = 32'(m_wrap_lo);
            div     = (m_duty == '0) ? 16'd1 : WRAP_W'(m_duty);
            m_wrap  = top[WRAP_W-1:0];
            m_level = m_wrap / div;
          end
          m_ms_left = MS_W'(tune_ms[m_note]);
          m_note    = m_note + 1'b1;
        end
      end
    end
    r.wrap    = m_wrap;
    r.level   = m_level;
    r.tone_on = (m_level != '0);
    r.busy    = m_playing;
    return r;
  endfunction

  // Result checking and receiver stall bursts
  always @(posedge clk) begin
    tone_out_t want;
    if (out_valid && !out_stall) begin
      if (tone_expect_q.size() == 0) begin
        $display("%0t: result with nothing expected: wrap %0d level %0d tone %0b busy %0b",
                 $time, out_pwm_wrap, out_pwm_level, out_tone_on, out_busy_res);
        faults++;
      end else begin
        want = tone_expect_q.pop_front();
        if (out_pwm_wrap !== want.wrap) begin
          $display("%0t: pwm_wrap expected %0d actual %0d", $time, want.wrap, out_pwm_wrap);
          faults++;
        end
        if (out_pwm_level !== want.level) begin
          $display("%0t: pwm_level expected %0d actual %0d", $time, want.level, out_pwm_level);
          faults++;
        end
        if (out_tone_on !== want.tone_on) begin
          $display("%0t: tone_on expected %0b actual %0b", $time, want.tone_on, out_tone_on);
          faults++;
        end
        if (out_busy_res !== want.busy) begin
          $display("%0t: busy_res expected %0b actual %0b", $time, want.busy, out_busy_res);
          faults++;
        end
      end
    end
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Send one item, with an occasional gap first; valid stays high afterwards
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [EFF_W-1:0] id);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_effect_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tone_expect_q.push_back(predict_tone(cmd, id));
  endtask

  // Drop valid and wait until every result is back and the block is quiet
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tone_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers while idle; narrow registers get junk in the upper bits
  task automatic program_tone_regs(input logic [CLK_W-1:0] clk_hz,
                                   input logic [WRAP_W-1:0] lo, input logic [WRAP_W-1:0] hi,
                                   input logic [DUTY_W-1:0] duty);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_TONE_CLK;
    cfg_wdata <= clk_hz;
    @(posedge clk);
    cfg_index <= REG_WRAP_MIN;
    cfg_wdata <= {JUNK_WRAP_W'($urandom), lo};
    @(posedge clk);
    cfg_index <= REG_WRAP_MAX;
    cfg_wdata <= {JUNK_WRAP_W'($urandom), hi};
    @(posedge clk);
    cfg_index <= REG_DUTY_DIV;
    cfg_wdata <= {JUNK_DUTY_W'($urandom), duty};
    @(posedge clk);
    cfg_we     <= 1'b0;
    m_tone_clk  = clk_hz;
    m_wrap_lo   = lo;
    m_wrap_hi   = hi;
    m_duty      = duty;
  endtask

  // Mostly well-formed plays: a start, then a run of ticks with sparse stray commands
  task automatic play_random_effects(input int n_items);
    int               sent;
    int               run;
    logic [EFF_W-1:0] id;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 6) id = brief_fx[$urandom_range(0, 4)];
      else id = EFF_W'($urandom_range(0, EFFECT_COUNT - 1));
      send_item(($urandom_range(0, 3) == 0) ? CMD_START_IDLE : CMD_START, id);
      run = $urandom_range(5, 90);
      // keep the item count close to the request
      if (run > n_items - sent - 1) run = n_items - sent - 1;
      for (int i = 0; i < run; i++) begin
        if ($urandom_range(0, 24) == 0)
          send_item(CMD_W'($urandom_range(0, 3)), EFF_W'($urandom));
        else
          send_item(CMD_TICK, EFF_W'($urandom));
      end
      sent += run + 1;
    end
  endtask

  // Ticks and the ignored command while idle leave the reset outputs
  task automatic test_idle_commands();
    send_item(CMD_TICK, '0);
    send_item(CMD_NOP, '1);
    send_item(CMD_TICK, '1);
  endtask

  // Start rules: empty slot, start-if-idle while busy, restart while busy
  task automatic test_start_rules();
    send_item(CMD_START, 4'd15);
    send_item(CMD_TICK, '0);
    send_item(CMD_START_IDLE, 4'd7);
    send_item(CMD_TICK, '0);
    send_item(CMD_START_IDLE, '0);
    send_item(CMD_NOP, '0);
    send_item(CMD_TICK, '0);
    send_item(CMD_START, 4'd3);
    send_item(CMD_TICK, '1);
    send_item(CMD_TICK, '0);
    send_item(CMD_START, '0);
    send_item(CMD_TICK, '0);
    send_item(CMD_START, 4'd10);
    send_item(CMD_TICK, '0);
    send_item(CMD_START, 4'd2);
    send_item(CMD_TICK, '0);
    send_item(CMD_START, 4'd14);
    send_item(CMD_TICK, '0);
    send_item(CMD_TICK, '0);
  endtask

  task automatic test_default_play();
    play_random_effects(70);
  endtask

  // Largest clock, widest clamps, largest divisor
  task automatic test_slowest_clock();
    program_tone_regs('1, '0, '1, '1);
    play_random_effects(60);
  endtask

  // Zero clock gives quotient zero; zero divisor acts as one
  task automatic test_zero_quotient();
    program_tone_regs('0, '0, 16'd777, '0);
    play_random_effects(60);
  endtask

  // Minimum above maximum; clock below some note frequencies
  task automatic test_min_over_max();
    program_tone_regs(27'd1000, '1, '0, 8'd1);
    play_random_effects(60);
  endtask

  task automatic test_random_settings();
    repeat (2) begin
      program_tone_regs(CLK_W'($urandom_range(1000, 125000000)),
                        WRAP_W'($urandom_range(0, 2000)),
                        WRAP_W'($urandom_range(1000, 65535)),
                        DUTY_W'($urandom_range(1, 255)));
      play_random_effects(60);
    end
  endtask

  // Back to reset settings with no gaps or stalls
  task automatic test_steady_flow();
    program_tone_regs(TONE_CLK_RST, WRAP_MIN_RST, WRAP_MAX_RST, DUTY_DIV_RST);
    calm = 1'b1;
    play_random_effects(60);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_commands();
    test_start_rules();
    test_default_play();
    test_slowest_clock();
    test_zero_quotient();
    test_min_over_max();
    test_random_settings();
    test_steady_flow();
    settle_idle();
    repeat (50) @(posedge clk);
    if (faults == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
src/setsq_pkg.sv
src/sound_effect_tone_sequencer_top.sv
src/setsq_checker.sv
tb/tb_sound_effect_tone_sequencer_top.sv
